### sv/rpp_pkg.sv
`timescale 1ns / 1ps
// shared constants for the vertex rotation and projection block
// register codes, field widths, reset values and the quarter-wave sine table
package rpp_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 10;
    localparam int TRIG_FRAC_DEF  = 14;

    // fixed formats
    localparam int TABLE_FRAC = 15;
    localparam int ZOOM_FRAC  = 8;
    localparam int ANGLE_W    = 9;
    localparam int ZOOM_W     = 10;
    localparam int CENTER_W   = 10;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd5;

    localparam logic [ANGLE_W-1:0]  ANGLE_X_RST  = 9'd45;
    localparam logic [ANGLE_W-1:0]  ANGLE_Y_RST  = 9'd30;
    localparam logic [ANGLE_W-1:0]  ANGLE_Z_RST  = 9'd0;
    localparam logic [ZOOM_W-1:0]   ZOOM_RST     = 10'd384;
    localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd240;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd136;

    // register stages from input register to output register
    localparam int PIPE_STAGES = 10;

    // sin(k deg) * 2^15, k = 0..90
    localparam int SINE_ENTRIES = 91;
    localparam logic [15:0] SINE_TAB [0:SINE_ENTRIES-1] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

endpackage

### sv/rpp_trig.sv
`timescale 1ns / 1ps
// sine and cosine of the three rotation angles, registered
// depends on rpp_pkg for the quarter-wave table and angle width
module rpp_trig #(
    parameter int TRIG_FRAC_BITS = rpp_pkg::TRIG_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic [rpp_pkg::ANGLE_W-1:0]       i_angle_x,
    input  logic [rpp_pkg::ANGLE_W-1:0]       i_angle_y,
    input  logic [rpp_pkg::ANGLE_W-1:0]       i_angle_z,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_sin_x,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_cos_x,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_sin_y,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_cos_y,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_sin_z,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_cos_z
);
    import rpp_pkg::*;

    localparam int F   = TRIG_FRAC_BITS;
    localparam int TW  = F + 2;
    localparam int SH  = TABLE_FRAC - F;
    localparam logic [16:0] RND = 17'((1 << SH) >> 1);
    localparam logic [ANGLE_W-1:0] FULL_TURN = 9'd360;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 9'd180;
    localparam logic [ANGLE_W-1:0] QUARTER   = 9'd90;
    localparam logic [ANGLE_W-1:0] THREE_Q   = 9'd270;

    // 360..511 folds to 0..151
    function automatic logic [ANGLE_W-1:0] reduce_deg(input logic [ANGLE_W-1:0] d);
        reduce_deg = (d >= FULL_TURN) ? d - FULL_TURN : d;
    endfunction

    function automatic logic signed [TW-1:0] sine_deg(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W-1:0] r;
        logic [6:0]         idx;
        logic               neg;
        logic [16:0]        m;
        r   = reduce_deg(d);
        neg = 1'b0;
        if (r < QUARTER) begin
            idx = r[6:0];
        end else if (r < HALF_TURN) begin
            idx = 7'(HALF_TURN - r);
        end else if (r < THREE_Q) begin
            idx = 7'(r - HALF_TURN);
            neg = 1'b1;
        end else begin
            idx = 7'(FULL_TURN - r);
            neg = 1'b1;
        end
        m = (17'(SINE_TAB[idx]) + RND) >> SH;
        sine_deg = neg ? -$signed({1'b0, m[F:0]}) : $signed({1'b0, m[F:0]});
    endfunction

    logic signed [TW-1:0] n_sin_x, n_cos_x, n_sin_y, n_cos_y, n_sin_z, n_cos_z;

    always_comb begin
        n_sin_x = sine_deg(i_angle_x);
        n_cos_x = sine_deg(reduce_deg(i_angle_x) + QUARTER);
        n_sin_y = sine_deg(i_angle_y);
        n_cos_y = sine_deg(reduce_deg(i_angle_y) + QUARTER);
        n_sin_z = sine_deg(i_angle_z);
        n_cos_z = sine_deg(reduce_deg(i_angle_z) + QUARTER);
    end

    // registered, follows the angle registers
    always_ff @(posedge i_clk) begin
        o_sin_x <= n_sin_x;
        o_cos_x <= n_cos_x;
        o_sin_y <= n_sin_y;
        o_cos_y <= n_cos_y;
        o_sin_z <= n_sin_z;
        o_cos_z <= n_cos_z;
    end

endmodule

### sv/rotate_project_points_top.sv
`timescale 1ns / 1ps
// vertex rotation (x, then z, then y axis) and screen projection, top level
// depends on rpp_pkg and rpp_trig
//
// usage
//   config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks
//     angle_x, angle_y, angle_z, zoom_scale, center_x, center_y (0..5), higher
//     indexes are ignored; write only while no item is in flight
//   input channel: one vertex (x, y, z signed) per item on i_in_valid / o_in_ready
//   output channel: screen_x, screen_y and clipped on o_out_valid / i_out_ready
//   throughput: one item per clock unless the output stalls, ten register
//     stages from input register to output register with at most one
//     multiplier layer per stage
//   angle writes reach the trig registers in the next cycle, before the
//     product stage of any later item reads them
//   reset: synchronous, active low; registers take their defaults (45, 30, 0
//     deg, zoom 1.5, center 240/136) and every stage is emptied
//   stall: a held result stays on the output; earlier stages keep moving
//     into empty slots, and o_in_ready drops only when every stage is full
module rotate_project_points_top #(
    parameter int COORD_BITS     = rpp_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = rpp_pkg::TRIG_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // vertex in
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [COORD_BITS-1:0]      i_vertex_x,
    input  logic signed [COORD_BITS-1:0]      i_vertex_y,
    input  logic signed [COORD_BITS-1:0]      i_vertex_z,
    // screen point out
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [COORD_BITS-1:0]             o_screen_x,
    output logic [COORD_BITS-1:0]             o_screen_y,
    output logic                              o_clipped
);
    import rpp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int F   = TRIG_FRAC_BITS;
    localparam int TW  = F + 2;               // trig value width
    localparam int WM1 = CB + TW;             // vertex times trig
    localparam int WR  = WM1 + 1;             // rotated coordinate, F fraction bits
    localparam int WH  = WR + TW;             // rotated coordinate times trig
    localparam int ZS  = F + ZOOM_FRAC;       // fraction bits after zoom
    localparam int WP  = WR + ZOOM_W + 1;     // coordinate times zoom
    localparam int WC  = CENTER_W + ZS + 1;   // aligned center
    localparam int WS  = ((WP > WC) ? WP : WC) + 1;
    localparam int WQ  = WS - ZS;             // integer screen value
    localparam int NS  = PIPE_STAGES;

    localparam logic signed [WH:0]    HALF_F     = (WH+1)'(1 << (F - 1));
    localparam logic signed [WS-1:0]  TRUNC_BIAS = WS'((1 << ZS) - 1);
    localparam logic signed [WQ-1:0]  MAX_Q      = WQ'((1 << CB) - 1);

    // truncate toward zero, then clamp to the screen; msb is the clip flag
    function automatic logic [CB:0] clamp_coord(input logic signed [WS-1:0] s);
        logic signed [WS-1:0] t;
        logic signed [WQ-1:0] q;
        logic [CB:0]          res;
        t = s[WS-1] ? s + TRUNC_BIAS : s;
        q = t[WS-1:ZS];
        if (q < 0) begin
            res = {1'b1, {CB{1'b0}}};
        end else if (q > MAX_Q) begin
            res = {1'b1, {CB{1'b1}}};
        end else begin
            res = {1'b0, q[CB-1:0]};
        end
        clamp_coord = res;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]  r_angle_x, r_angle_y, r_angle_z;
    logic [ZOOM_W-1:0]   r_zoom;
    logic [CENTER_W-1:0] r_center_x, r_center_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_x  <= ANGLE_X_RST;
            r_angle_y  <= ANGLE_Y_RST;
            r_angle_z  <= ANGLE_Z_RST;
            r_zoom     <= ZOOM_RST;
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ANGLE_X:  r_angle_x  <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_Y:  r_angle_y  <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_Z:  r_angle_z  <= i_cfg_data[ANGLE_W-1:0];
                CFG_ZOOM:     r_zoom     <= i_cfg_data[ZOOM_W-1:0];
                CFG_CENTER_X: r_center_x <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[CENTER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sine / cosine registers, refreshed every cycle from the angles
    logic signed [TW-1:0] w_sin_x, w_cos_x, w_sin_y, w_cos_y, w_sin_z, w_cos_z;

    rpp_trig #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_trig (
        .i_clk     (i_clk),
        .i_angle_x (r_angle_x),
        .i_angle_y (r_angle_y),
        .i_angle_z (r_angle_z),
        .o_sin_x   (w_sin_x),
        .o_cos_x   (w_cos_x),
        .o_sin_y   (w_sin_y),
        .o_cos_y   (w_cos_y),
        .o_sin_z   (w_sin_z),
        .o_cos_z   (w_cos_z)
    );

    logic signed [WP-1:0] w_zoom_s;
    assign w_zoom_s = WP'($signed({1'b0, r_zoom}));

    // ------------------------------------------------------------------
    // stage control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        n_v = {r_v[NS-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NS-1];

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    // stage 0: input register
    logic signed [CB-1:0] r0_vx, r0_vy, r0_vz;
    // stage 1: vertex times trig
    logic signed [WM1-1:0] r1_ycx, r1_zsx, r1_ysx, r1_zcx, r1_xcz, r1_xsz;
    // stage 2: first rotation (about x), exact since inputs are whole numbers
    logic signed [WR-1:0]  r2_y1, r2_z1;
    logic signed [WM1-1:0] r2_xcz, r2_xsz;
    // stage 3: y1 times z trig
    logic signed [WH-1:0]  r3_ysz, r3_ycz;
    logic signed [WM1-1:0] r3_xcz, r3_xsz;
    logic signed [WR-1:0]  r3_z1;
    // stage 4: second rotation (about z)
    logic signed [WR-1:0]  r4_x2, r4_y2, r4_z1;
    // stage 5: y trig products and y zoom
    logic signed [WH-1:0]  r5_xcy, r5_zsy;
    logic signed [WP-1:0]  r5_yzm;
    // stage 6: third rotation (about y), y offset
    logic signed [WR-1:0]  r6_x3;
    logic signed [WS-1:0]  r6_sum_y;
    // stage 7: x zoom, y clamp
    logic signed [WP-1:0]  r7_xzm;
    logic [CB-1:0]         r7_sy;
    logic                  r7_clip_y;
    // stage 8: x offset
    logic signed [WS-1:0]  r8_sum_x;
    logic [CB-1:0]         r8_sy;
    logic                  r8_clip_y;

    logic signed [WR-1:0] n_x2, n_y2, n_x3;
    logic signed [WH:0]   n_tx, n_ty, n_t3;
    logic signed [WS-1:0] n_sum_y, n_sum_x;
    logic [CB:0]          n_cy, n_cx;

    always_comb begin
        // round half up at F fraction bits
        n_tx = HALF_F - (WH+1)'(r3_ysz);
        n_ty = HALF_F + (WH+1)'(r3_ycz);
        n_x2 = WR'(r3_xcz) + WR'(n_tx >>> F);
        n_y2 = WR'(r3_xsz) + WR'(n_ty >>> F);

        n_t3 = (WH+1)'(r5_xcy) - (WH+1)'(r5_zsy) + HALF_F;
        n_x3 = WR'(n_t3 >>> F);

        n_sum_y = WS'(r5_yzm) + (WS'($signed({1'b0, r_center_y})) <<< ZS);
        n_sum_x = WS'(r7_xzm) + (WS'($signed({1'b0, r_center_x})) <<< ZS);

        n_cy = clamp_coord(r6_sum_y);
        n_cx = clamp_coord(r8_sum_x);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_vx <= i_vertex_x;
            r0_vy <= i_vertex_y;
            r0_vz <= i_vertex_z;
        end
        if (w_en[1]) begin
            r1_ycx <= WM1'(r0_vy) * WM1'(w_cos_x);
            r1_zsx <= WM1'(r0_vz) * WM1'(w_sin_x);
            r1_ysx <= WM1'(r0_vy) * WM1'(w_sin_x);
            r1_zcx <= WM1'(r0_vz) * WM1'(w_cos_x);
            r1_xcz <= WM1'(r0_vx) * WM1'(w_cos_z);
            r1_xsz <= WM1'(r0_vx) * WM1'(w_sin_z);
        end
        if (w_en[2]) begin
            r2_y1  <= WR'(r1_ycx) - WR'(r1_zsx);
            r2_z1  <= WR'(r1_ysx) + WR'(r1_zcx);
            r2_xcz <= r1_xcz;
            r2_xsz <= r1_xsz;
        end
        if (w_en[3]) begin
            r3_ysz <= WH'(r2_y1) * WH'(w_sin_z);
            r3_ycz <= WH'(r2_y1) * WH'(w_cos_z);
            r3_xcz <= r2_xcz;
            r3_xsz <= r2_xsz;
            r3_z1  <= r2_z1;
        end
        if (w_en[4]) begin
            r4_x2 <= n_x2;
            r4_y2 <= n_y2;
            r4_z1 <= r3_z1;
        end
        if (w_en[5]) begin
            r5_xcy <= WH'(r4_x2) * WH'(w_cos_y);
            r5_zsy <= WH'(r4_z1) * WH'(w_sin_y);
            r5_yzm <= WP'(r4_y2) * w_zoom_s;
        end
        if (w_en[6]) begin
            r6_x3    <= n_x3;
            r6_sum_y <= n_sum_y;
        end
        if (w_en[7]) begin
            r7_xzm    <= WP'(r6_x3) * w_zoom_s;
            r7_sy     <= n_cy[CB-1:0];
            r7_clip_y <= n_cy[CB];
        end
        if (w_en[8]) begin
            r8_sum_x  <= n_sum_x;
            r8_sy     <= r7_sy;
            r8_clip_y <= r7_clip_y;
        end
        if (w_en[9]) begin
            o_screen_x <= n_cx[CB-1:0];
            o_screen_y <= r8_sy;
            o_clipped  <= n_cx[CB] | r8_clip_y;
        end
    end

endmodule

### sv/rpp_checker.sv
`timescale 1ns / 1ps
// port-level checks for the rotation and projection block, with its bind
// depends on rpp_pkg for the stage count
module rpp_checker #(
    parameter int COORD_BITS = rpp_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_screen_x,
    input logic [COORD_BITS-1:0] o_screen_y,
    input logic                  o_clipped
);
    import rpp_pkg::*;

    localparam int CW = $clog2(PIPE_STAGES + 1);
    localparam logic [COORD_BITS-1:0] MAXV = {COORD_BITS{1'b1}};
    localparam logic [CW-1:0] DEPTH = CW'(PIPE_STAGES);

    logic          w_in_acc, w_out_acc;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt + CW'(w_in_acc) - CW'(w_out_acc);
    end

    // items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("result shown with no item in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH)
        else $error("more items in flight than stages");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_screen_x == '0 || o_screen_x == MAXV ||
             o_screen_y == '0 || o_screen_y == MAXV))
        else $error("clipped flag without a clamped coordinate");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_screen_x) && $stable(o_screen_y) &&
             $stable(o_clipped)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind rotate_project_points_top rpp_checker #(
    .COORD_BITS(COORD_BITS)
) u_rpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_screen_x  (o_screen_x),
    .o_screen_y  (o_screen_y),
    .o_clipped   (o_clipped)
);

### tb/sv/tb_rotate_project_points_top.sv
`timescale 1ns / 1ps
// self-checking bench for rotate_project_points_top: vertices go in through a
// stalling handshake, every screen point is checked against a local predictor
// depends on rpp_pkg and the rotate_project_points rtl
module tb_rotate_project_points_top;
    import rpp_pkg::*;

    localparam int PT_BITS  = COORD_BITS_DEF;
    localparam int FRAC     = TRIG_FRAC_DEF;
    localparam int N_PHASES = 14;
    localparam int PHASE_ITEMS = 125;
    localparam int LONG_HOLD   = 120;
    localparam int MAX_PRINTS  = 100;

    // indexes with no register behind them, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // quadrant edges and range ends for the angle registers
    localparam int ANG_EDGES [0:11] = '{0, 1, 89, 90, 91, 179, 180, 181, 269, 270, 271, 359};

    typedef struct packed {
        logic signed [PT_BITS-1:0] x;
        logic signed [PT_BITS-1:0] y;
        logic signed [PT_BITS-1:0] z;
    } t_vertex;

    typedef struct packed {
        logic [PT_BITS-1:0] sx;
        logic [PT_BITS-1:0] sy;
        logic               clip;
    } t_screen_pt;

    // clock and reset
    logic i_clk;
    logic i_rst_n = 1'b0;

    // dut ports, all driven from time zero
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_ANGLE_X;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [PT_BITS-1:0]  i_vertex_x  = '0;
    logic signed [PT_BITS-1:0]  i_vertex_y  = '0;
    logic signed [PT_BITS-1:0]  i_vertex_z  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [PT_BITS-1:0]         o_screen_x;
    logic [PT_BITS-1:0]         o_screen_y;
    logic                       o_clipped;

    // local copy of the view registers, starts at the reset values
    logic [ANGLE_W-1:0]  rot_x_deg = ANGLE_X_RST;
    logic [ANGLE_W-1:0]  rot_y_deg = ANGLE_Y_RST;
    logic [ANGLE_W-1:0]  rot_z_deg = ANGLE_Z_RST;
    logic [ZOOM_W-1:0]   zoom_q48  = ZOOM_RST;
    logic [CENTER_W-1:0] ctr_x     = CENTER_X_RST;
    logic [CENTER_W-1:0] ctr_y     = CENTER_Y_RST;

    // vertices waiting to be offered, screen points waiting to come out
    t_vertex    vertex_q [$];
    t_screen_pt screen_q [$];
    t_vertex    cur_vtx;          // payload currently on the input port
    logic       in_pending = 1'b0; // an item is being offered and not yet taken

    // idling control
    int   src_gap = 0;
    int   snk_hold = 0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    logic long_hold_req = 1'b0;

    int   err_cnt = 0;

    rotate_project_points_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_vertex_x  (i_vertex_x),
        .i_vertex_y  (i_vertex_y),
        .i_vertex_z  (i_vertex_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_clipped   (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // fold any 9-bit angle into 0..359
    function automatic int unsigned wrap_deg(input int unsigned d);
        d = d & 511;
        if (d >= 360) d = d - 360;
        return d;
    endfunction

    // sine in FRAC fraction bits, mirrored from the quarter table
    function automatic longint sin_q(input int unsigned deg_in);
        int unsigned d;
        int unsigned idx;
        logic        neg;
        longint      m;
        d   = wrap_deg(deg_in);
        neg = 1'b0;
        if (d < 90) begin
            idx = d;
        end else if (d < 180) begin
            idx = 180 - d;
        end else if (d < 270) begin
            idx = d - 180;
            neg = 1'b1;
        end else begin
            idx = 360 - d;
            neg = 1'b1;
        end
        m = (longint'(SINE_TAB[idx]) + ((longint'(1) << (TABLE_FRAC - FRAC)) >>> 1))
            >>> (TABLE_FRAC - FRAC);
        return neg ? -m : m;
    endfunction

    // back to FRAC fraction bits, nearest with ties upward (floor shift)
    function automatic longint rnd_frac(input longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    // scale, offset, truncate toward zero, clamp; msb is the clip flag
    function automatic logic [PT_BITS:0] place(input longint r, input longint ctr);
        longint sum;
        longint q;
        sum = r * longint'(zoom_q48) + ctr * (longint'(1) << (FRAC + ZOOM_FRAC));
        q   = sum / (longint'(1) << (FRAC + ZOOM_FRAC));
        if (q < 0)
            return {1'b1, {PT_BITS{1'b0}}};
        if (q > (longint'(1) << PT_BITS) - 1)
            return {1'b1, {PT_BITS{1'b1}}};
        return {1'b0, q[PT_BITS-1:0]};
    endfunction

    // rotate about x, then z, then y, and map onto the screen
    function automatic t_screen_pt project_vertex(input t_vertex v);
        longint sx, cx, sy, cy, sz, cz;
        longint x0, y0, z0, y1, z1, x2, y2, x3;
        logic [PT_BITS:0] px, py;
        t_screen_pt p;
        sx = sin_q(rot_x_deg);
        cx = sin_q(wrap_deg(rot_x_deg) + 90);
        sy = sin_q(rot_y_deg);
        cy = sin_q(wrap_deg(rot_y_deg) + 90);
        sz = sin_q(rot_z_deg);
        cz = sin_q(wrap_deg(rot_z_deg) + 90);
        x0 = longint'($signed(v.x)) * (longint'(1) << FRAC);
        y0 = longint'($signed(v.y)) * (longint'(1) << FRAC);
        z0 = longint'($signed(v.z)) * (longint'(1) << FRAC);
        y1 = rnd_frac(y0 * cx - z0 * sx);
        z1 = rnd_frac(y0 * sx + z0 * cx);
        x2 = rnd_frac(x0 * cz - y1 * sz);
        y2 = rnd_frac(x0 * sz + y1 * cz);
        x3 = rnd_frac(x2 * cy - z1 * sy);
        px = place(x3, longint'(ctr_x));
        py = place(y2, longint'(ctr_y));
        p.sx   = px[PT_BITS-1:0];
        p.sy   = py[PT_BITS-1:0];
        p.clip = px[PT_BITS] | py[PT_BITS];
        return p;
    endfunction

    task automatic report_err(input string what);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // driver: new item or idle decision only once the previous item is gone,
    // so valid and payload hold steady while the dut stalls
    always @(negedge i_clk) begin
        if (i_rst_n && !in_pending) begin
            if (src_gap > 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (vertex_q.size() > 0 && src_idle_pct > 0 &&
                         $urandom_range(0, 99) < src_idle_pct) begin
                // idle burst of random length, this one included
                src_gap = $urandom_range(0, 12);
                i_in_valid <= 1'b0;
            end else if (vertex_q.size() > 0) begin
                cur_vtx = vertex_q.pop_front();
                i_vertex_x <= cur_vtx.x;
                i_vertex_y <= cur_vtx.y;
                i_vertex_z <= cur_vtx.z;
                i_in_valid <= 1'b1;
                in_pending = 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // item taken: predict with the registers as they stand now
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            screen_q.push_back(project_vertex(cur_vtx));
            in_pending = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver back-pressure: random bursts, plus one long hold on request
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            snk_hold = LONG_HOLD;
            long_hold_req = 1'b0;
            i_out_ready <= 1'b0;
        end else if (snk_hold > 0) begin
            snk_hold--;
            i_out_ready <= 1'b0;
        end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
            snk_hold = $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: in-order compare against the oldest prediction
    always @(posedge i_clk) begin : mon
        t_screen_pt want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (screen_q.size() == 0) begin
                report_err("screen point with no vertex outstanding");
            end else begin
                want = screen_q.pop_front();
                if (o_screen_x !== want.sx)
                    report_err($sformatf("screen_x %0d, want %0d", o_screen_x, want.sx));
                if (o_screen_y !== want.sy)
                    report_err($sformatf("screen_y %0d, want %0d", o_screen_y, want.sy));
                if (o_clipped !== want.clip)
                    report_err($sformatf("clipped %0b, want %0b", o_clipped, want.clip));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic queue_vertex(input int x, input int y, input int z);
        t_vertex v;
        v.x = x[PT_BITS-1:0];
        v.y = y[PT_BITS-1:0];
        v.z = z[PT_BITS-1:0];
        vertex_q.push_back(v);
    endtask

    // called on a falling edge, returns on a falling edge with valid still high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ANGLE_X:  rot_x_deg = data[ANGLE_W-1:0];
            CFG_ANGLE_Y:  rot_y_deg = data[ANGLE_W-1:0];
            CFG_ANGLE_Z:  rot_z_deg = data[ANGLE_W-1:0];
            CFG_ZOOM:     zoom_q48  = data[ZOOM_W-1:0];
            CFG_CENTER_X: ctr_x     = data[CENTER_W-1:0];
            CFG_CENTER_Y: ctr_y     = data[CENTER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // full view update, then a junk write to a dead index that must not land
    task automatic set_view(input logic [CFG_DATA_W-1:0] ax, input logic [CFG_DATA_W-1:0] ay,
                            input logic [CFG_DATA_W-1:0] az, input logic [CFG_DATA_W-1:0] zm,
                            input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy);
        write_reg(CFG_ANGLE_X, ax);
        write_reg(CFG_ANGLE_Y, ay);
        write_reg(CFG_ANGLE_Z, az);
        write_reg(CFG_ZOOM, zm);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                  CFG_DATA_W'($urandom_range(0, 1023)));
        i_cfg_valid <= 1'b0;
    endtask

    // block until every queued vertex went in and its point came out
    task automatic wait_idle();
        while (vertex_q.size() != 0 || in_pending || screen_q.size() != 0)
            @(negedge i_clk);
    endtask

    // edge angles half the time, otherwise anything the 10-bit port can carry
    function automatic logic [CFG_DATA_W-1:0] pick_angle();
        if ($urandom_range(0, 1))
            return CFG_DATA_W'(ANG_EDGES[$urandom_range(0, 11)]);
        return CFG_DATA_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ctr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] zm;
        int sel;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset view, coordinate extremes
        queue_vertex(0, 0, 0);
        queue_vertex(511, 511, 511);
        queue_vertex(-512, -512, -512);
        queue_vertex(511, -512, 0);
        queue_vertex(-512, 511, -1);
        queue_vertex(-1, -1, -1);
        queue_vertex(1, 0, -1);
        queue_vertex(300, -300, 100);
        wait_idle();

        // no rotation, half zoom, corner center: minus a half truncates to
        // zero unclipped, minus one clips low
        set_view(0, 0, 0, 128, 0, 0);
        queue_vertex(-1, -1, 0);
        queue_vertex(-2, 0, 0);
        queue_vertex(0, -2, 0);
        queue_vertex(511, 511, 0);
        wait_idle();

        // max zoom, far corner: overflow clips high
        set_view(0, 0, 0, 1023, 1023, 1023);
        queue_vertex(1, 1, 0);
        queue_vertex(0, 0, 0);
        queue_vertex(-1, -1, 0);
        wait_idle();

        // zoom zero pins every vertex on the center
        set_view(90, 180, 270, 0, 512, 0);
        queue_vertex(511, -512, 7);
        queue_vertex(-512, 511, -512);
        wait_idle();

        // angles past 359 wrap, data bit above the angle width is dropped
        set_view(360, 10'h3FF, 600, 256, 300, 700);
        queue_vertex(100, -200, 300);
        queue_vertex(-512, 511, 511);
        wait_idle();

        // random phases, each with its own view and idling mix
        for (int k = 0; k < N_PHASES; k++) begin
            if (k == 0) begin
                set_view(0, 0, 0, 0, 0, 0);
            end else if (k == 1) begin
                set_view(359, 359, 359, 1023, 1023, 1023);
            end else begin
                sel = $urandom_range(0, 9);
                if (sel == 0) zm = 0;
                else if (sel == 1) zm = 1;
                else if (sel == 2) zm = 1023;
                else if (sel < 6) zm = CFG_DATA_W'($urandom_range(64, 512));
                else zm = CFG_DATA_W'($urandom_range(0, 1023));
                set_view(pick_angle(), pick_angle(), pick_angle(), zm, pick_ctr(), pick_ctr());
            end

            // last phases run flat out, the rest mix none, light and heavy idling
            if (k >= N_PHASES - 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = 15 * $urandom_range(0, 2);
                snk_idle_pct = 15 * $urandom_range(0, 2);
            end

            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if ($urandom_range(0, 3) == 0)
                    queue_vertex(int'($urandom_range(0, 127)) - 64,
                                 int'($urandom_range(0, 127)) - 64,
                                 int'($urandom_range(0, 127)) - 64);
                else
                    queue_vertex(int'($urandom_range(0, 1023)) - 512,
                                 int'($urandom_range(0, 1023)) - 512,
                                 int'($urandom_range(0, 1023)) - 512);
            end

            // long output hold while the sender keeps pushing, fills the pipe
            if (k == 3) begin
                src_idle_pct = 0;
                long_hold_req = 1'b1;
            end
            wait_idle();
        end

        // drain margin past the pipeline depth
        repeat (PIPE_STAGES + 10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/rpp_pkg.sv
sv/rpp_trig.sv
sv/rotate_project_points_top.sv
sv/rpp_checker.sv
tb/sv/tb_rotate_project_points_top.sv
